[hw/rtl/tcc_pkg.sv]
// Shared types and constants for the text console cursor controller.
// Used by tcc_cursor, tcc_out_queue and text_console_cursor_controller.
package tcc_pkg;

  localparam int unsigned COL_W = 8;
  localparam int unsigned ROW_W = 7;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned CMD_W = 2;
  localparam int unsigned COLS_REG_W = 9;
  localparam int unsigned ROWS_REG_W = 8;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned MAX_CMDS = 3;
  localparam int unsigned CNT_W = 2;

  // Tab stops every 2**TAB_SHIFT columns
  localparam int unsigned TAB_SHIFT = 2;
  localparam int unsigned TAB_COLUMNS = 1 << TAB_SHIFT;

  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_COLUMNS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_ROWS = 1'd1;

  localparam logic [MODE_W-1:0] MODE_CHAR = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BACKSPACE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DOWN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LEFT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RIGHT = 3'd5;
  localparam logic [MODE_W-1:0] MODE_BLINK = 3'd6;

  localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_SHOW  = 2'd2,
    CMD_HIDE  = 2'd3
  } tcc_command_t;

  typedef struct packed {
    tcc_command_t      command;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CHAR_W-1:0] glyph;
  } tcc_cmd_t;

  // All commands caused by one input item
  typedef struct packed {
    tcc_cmd_t [MAX_CMDS-1:0] cmds;
    logic [CNT_W-1:0]        count;
    logic                    held;
  } tcc_bundle_t;

endpackage

[hw/rtl/text_console_cursor_controller.sv]
// Top level of the text console cursor controller: input register, screen
// size registers, cursor logic and result register. Depends on tcc_pkg.
//
// Takes console items (character, backspace, arrow move, blink tick) on the
// s_ stream and emits up to three cell commands per item on the m_ stream,
// one command per cycle while m_tready is high, tlast on the final one. Arrow
// moves at the screen edge and mode 7 produce no command. An item holds the
// result register until all its commands (1 to 3) are taken; an item with no
// commands leaves it free. The input register accepts the next item while the
// previous item's commands drain. The user must write the screen size
// registers only while the block is idle; the block itself does not enforce it.
module text_console_cursor_controller (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_we,
  input  logic [tcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tcc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input items
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] char_code
  input  logic [2:0]                       s_tuser,   // [2:0] mode
  // cell commands
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [7:0] cell_column, [14:8] cell_row, [22:15] glyph_code, [23] row_saturated
  output logic [23:0]                      m_tdata,
  output logic [1:0]                       m_tuser,   // [1:0] command
  output logic                             m_tlast
);

  logic [tcc_pkg::COLS_REG_W-1:0] screen_columns;
  logic [tcc_pkg::ROWS_REG_W-1:0] screen_rows;
  logic [tcc_pkg::COL_W-1:0]      last_col;
  logic [tcc_pkg::ROW_W-1:0]      last_row;

  logic                           in_valid;
  logic [tcc_pkg::MODE_W-1:0]     in_mode;
  logic [tcc_pkg::CHAR_W-1:0]     in_char;

  logic                           fire;
  logic                           q_free;
  logic                           q_held;
  logic                           q_last;
  tcc_pkg::tcc_bundle_t           bundle;
  tcc_pkg::tcc_cmd_t              head;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns <= 9'd128;
      screen_rows <= 8'd48;
    end else if (cfg_we) begin
      case (cfg_index)
        tcc_pkg::REG_SCREEN_COLUMNS: screen_columns <= cfg_data;
        tcc_pkg::REG_SCREEN_ROWS:    screen_rows <= cfg_data[tcc_pkg::ROWS_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    if (screen_columns == '0) begin
      last_col = '0;
    end else if (screen_columns[tcc_pkg::COLS_REG_W-1]) begin
      last_col = '1;
    end else begin
      last_col = screen_columns[tcc_pkg::COL_W-1:0] - 1'b1;
    end
    if (screen_rows == '0) begin
      last_row = '0;
    end else if (screen_rows[tcc_pkg::ROWS_REG_W-1]) begin
      last_row = '1;
    end else begin
      last_row = screen_rows[tcc_pkg::ROW_W-1:0] - 1'b1;
    end
  end

  assign fire = in_valid && q_free;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser;
      in_char <= s_tdata;
    end
  end

  tcc_cursor u_cursor (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .mode      (in_mode),
    .char_code (in_char),
    .last_col  (last_col),
    .last_row  (last_row),
    .bundle    (bundle)
  );

  tcc_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .bundle    (bundle),
    .free      (q_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .head      (head),
    .held      (q_held),
    .head_last (q_last)
  );

  assign m_tuser = head.command;
  assign m_tdata = {q_held, head.glyph, head.row, head.col};
  assign m_tlast = q_last;

endmodule

[hw/rtl/tcc_cursor.sv]
// Cursor state and per-item command generation for the console controller.
// Depends on tcc_pkg.
module tcc_cursor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [tcc_pkg::MODE_W-1:0]    mode,
  input  logic [tcc_pkg::CHAR_W-1:0]    char_code,
  input  logic [tcc_pkg::COL_W-1:0]     last_col,
  input  logic [tcc_pkg::ROW_W-1:0]     last_row,
  output tcc_pkg::tcc_bundle_t          bundle
);

  logic [tcc_pkg::COL_W-1:0] cursor_column, cursor_column_next;
  logic [tcc_pkg::ROW_W-1:0] cursor_row, cursor_row_next;
  logic                      cursor_shown, cursor_shown_next;

  logic [tcc_pkg::CNT_W-1:0]  n;
  logic [tcc_pkg::COL_W:0]    tab_col;
  logic [tcc_pkg::COL_W-1:0]  col_dec;
  logic                       at_last_row;
  logic                       at_last_col;
  logic [tcc_pkg::COL_W-1:0]  adv_col;
  logic [tcc_pkg::ROW_W-1:0]  adv_row;
  logic                       adv_held;

  function automatic tcc_pkg::tcc_cmd_t mk(input tcc_pkg::tcc_command_t command,
                                           input logic [tcc_pkg::COL_W-1:0] col,
                                           input logic [tcc_pkg::ROW_W-1:0] row,
                                           input logic [tcc_pkg::CHAR_W-1:0] glyph);
    tcc_pkg::tcc_cmd_t r;
    r.command = command;
    r.col = col;
    r.row = row;
    r.glyph = glyph;
    return r;
  endfunction

  // next tab stop strictly above the current column, may reach 256
  assign tab_col = ({1'b0, cursor_column[tcc_pkg::COL_W-1:tcc_pkg::TAB_SHIFT]}
                    + 1'b1) << tcc_pkg::TAB_SHIFT;
  assign col_dec = cursor_column - 1'b1;
  assign at_last_row = cursor_row >= last_row;
  assign at_last_col = cursor_column >= last_col;

  // line advance: row held at the last row
  assign adv_col = '0;
  assign adv_row = at_last_row ? last_row : cursor_row + 1'b1;
  assign adv_held = at_last_row;

  always_comb begin
    cursor_column_next = cursor_column;
    cursor_row_next = cursor_row;
    cursor_shown_next = cursor_shown;
    bundle.cmds = '0;
    bundle.held = 1'b0;
    n = '0;
    case (mode)
      tcc_pkg::MODE_CHAR: begin
        bundle.cmds[0] = mk(tcc_pkg::CMD_CLEAR, cursor_column, cursor_row, '0);
        n = 2'd1;
        if (char_code == tcc_pkg::CHAR_CR) begin
          cursor_column_next = '0;
        end else if (char_code == tcc_pkg::CHAR_LF) begin
          bundle.cmds[1] = mk(tcc_pkg::CMD_HIDE, cursor_column, cursor_row, '0);
          n = 2'd2;
          cursor_column_next = adv_col;
          cursor_row_next = adv_row;
          bundle.held = adv_held;
        end else if (char_code == tcc_pkg::CHAR_TAB) begin
          if (tab_col >= {1'b0, last_col}) begin
            bundle.cmds[1] = mk(tcc_pkg::CMD_HIDE, cursor_column, cursor_row, '0);
            n = 2'd2;
            cursor_column_next = adv_col;
            cursor_row_next = adv_row;
            bundle.held = adv_held;
          end else begin
            cursor_column_next = tab_col[tcc_pkg::COL_W-1:0];
          end
        end else begin
          bundle.cmds[1] = mk(tcc_pkg::CMD_DRAW, cursor_column, cursor_row, char_code);
          n = 2'd2;
          if (at_last_col) begin
            bundle.cmds[2] = mk(tcc_pkg::CMD_HIDE, cursor_column, cursor_row, '0);
            n = 2'd3;
            cursor_column_next = adv_col;
            cursor_row_next = adv_row;
            bundle.held = adv_held;
          end else begin
            cursor_column_next = cursor_column + 1'b1;
          end
        end
      end
      tcc_pkg::MODE_BACKSPACE: begin
        bundle.cmds[0] = mk(tcc_pkg::CMD_CLEAR, cursor_column, cursor_row, '0);
        if (cursor_column == '0) begin
          if (cursor_row != '0) begin
            cursor_column_next = last_col;
            cursor_row_next = cursor_row - 1'b1;
          end
        end else begin
          cursor_column_next = (col_dec > last_col) ? last_col : col_dec;
        end
        bundle.cmds[1] = mk(tcc_pkg::CMD_CLEAR, cursor_column_next, cursor_row_next, '0);
        n = 2'd2;
        if (cursor_shown) begin
          bundle.cmds[2] = mk(tcc_pkg::CMD_SHOW, cursor_column_next, cursor_row_next, '0);
          n = 2'd3;
        end
      end
      tcc_pkg::MODE_UP, tcc_pkg::MODE_DOWN, tcc_pkg::MODE_LEFT, tcc_pkg::MODE_RIGHT: begin
        // a move off the edge produces nothing
        if (!((mode == tcc_pkg::MODE_UP && cursor_row == '0) ||
              (mode == tcc_pkg::MODE_DOWN && at_last_row) ||
              (mode == tcc_pkg::MODE_LEFT && cursor_column == '0) ||
              (mode == tcc_pkg::MODE_RIGHT && at_last_col))) begin
          bundle.cmds[0] = mk(tcc_pkg::CMD_HIDE, cursor_column, cursor_row, '0);
          n = 2'd1;
          if (mode == tcc_pkg::MODE_UP) begin
            cursor_row_next = cursor_row - 1'b1;
          end else if (mode == tcc_pkg::MODE_DOWN) begin
            cursor_row_next = cursor_row + 1'b1;
          end else if (mode == tcc_pkg::MODE_LEFT) begin
            cursor_column_next = (col_dec > last_col) ? last_col : col_dec;
          end else begin
            cursor_column_next = cursor_column + 1'b1;
          end
          if (cursor_shown) begin
            bundle.cmds[1] = mk(tcc_pkg::CMD_SHOW, cursor_column_next, cursor_row_next, '0);
            n = 2'd2;
          end
        end
      end
      tcc_pkg::MODE_BLINK: begin
        cursor_shown_next = !cursor_shown;
        bundle.cmds[0] = mk(cursor_shown ? tcc_pkg::CMD_HIDE : tcc_pkg::CMD_SHOW,
                            cursor_column, cursor_row, '0);
        n = 2'd1;
      end
      default: begin
      end
    endcase
    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row <= '0;
      cursor_shown <= 1'b0;
    end else if (fire) begin
      cursor_column <= cursor_column_next;
      cursor_row <= cursor_row_next;
      cursor_shown <= cursor_shown_next;
    end
  end

endmodule

[hw/rtl/tcc_out_queue.sv]
// Result register: holds the commands of one item and sends them one a cycle while m_tready is high.
// Depends on tcc_pkg.
module tcc_out_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  tcc_pkg::tcc_bundle_t        bundle,
  output logic                        free,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output tcc_pkg::tcc_cmd_t           head,
  output logic                        held,
  output logic                        head_last
);

  tcc_pkg::tcc_cmd_t [tcc_pkg::MAX_CMDS-1:0] entries;
  logic [tcc_pkg::CNT_W-1:0]                 count;
  logic                                      take;

  assign m_tvalid = count != '0;
  assign take = m_tvalid && m_tready;
  // free when empty or when the final command leaves this cycle
  assign free = (count == '0) || (count == 2'd1 && m_tready);
  assign head = entries[0];
  assign head_last = count == 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= bundle.count;
    end else if (take) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entries <= bundle.cmds;
      held <= bundle.held;
    end else if (take) begin
      entries[0] <= entries[1];
      entries[1] <= entries[2];
    end
  end

endmodule

[sim/text_console_cursor_controller_tb.sv]
// Self-checking testbench for text_console_cursor_controller: directed and random
// console requests, predicted cell commands checked in order on the output stream.
// Depends on tcc_pkg and the controller RTL.
module text_console_cursor_controller_tb;

  localparam logic [tcc_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;

  typedef struct {
    logic [tcc_pkg::MODE_W-1:0] mode;
    logic [tcc_pkg::CHAR_W-1:0] ch;
  } console_req_t;

  typedef struct {
    tcc_pkg::tcc_cmd_t item;
    logic              held;
    logic              last;
  } cell_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [tcc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [tcc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;

  // screen size and cursor as the controller should hold them
  logic [tcc_pkg::COLS_REG_W-1:0] size_cols = 9'd128;
  logic [tcc_pkg::ROWS_REG_W-1:0] size_rows = 8'd48;
  int cur_col = 0;
  int cur_row = 0;
  bit cur_shown = 1'b0;

  console_req_t console_reqs[$];
  cell_cmd_t step_cmds[$];
  cell_cmd_t cmds_due[$];
  int reqs_queued = 0;
  int reqs_accepted = 0;
  int errors = 0;
  int src_wait = 0;
  int sink_wait = 0;
  bit calm_src = 1'b0;
  bit calm_sink = 1'b0;

  text_console_cursor_controller DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial forever #1 clk = ~clk;

  initial begin
    #400000;
    $display("text_console_cursor_controller: mismatch");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic void emit(tcc_pkg::tcc_command_t cmd, int col, int row,
                               logic [7:0] glyph);
    cell_cmd_t e;
    e.item.command = cmd;
    e.item.col = col[7:0];
    e.item.row = row[6:0];
    e.item.glyph = glyph;
    e.held = 1'b0;
    e.last = 1'b0;
    step_cmds.push_back(e);
  endfunction

  // column 0, next row; returns 1 when held at the last row
  function automatic bit advance_line(int lastr);
    cur_col = 0;
    if (cur_row + 1 > lastr) begin
      cur_row = lastr;
      return 1'b1;
    end
    cur_row = cur_row + 1;
    return 1'b0;
  endfunction

  function automatic void predict_cursor(logic [tcc_pkg::MODE_W-1:0] mode,
                                         logic [tcc_pkg::CHAR_W-1:0] ch);
    int c, r, lastc, lastr, nc;
    bit held;
    c = cur_col;
    r = cur_row;
    // zero acts as one, oversize clamps to the screen maximum
    lastc = (size_cols == 0) ? 0 : ((size_cols > 256) ? 255 : int'(size_cols) - 1);
    lastr = (size_rows == 0) ? 0 : ((size_rows > 128) ? 127 : int'(size_rows) - 1);
    held = 1'b0;
    step_cmds.delete();
    case (mode)
      tcc_pkg::MODE_CHAR: begin
        emit(tcc_pkg::CMD_CLEAR, c, r, 8'd0);
        if (ch == tcc_pkg::CHAR_CR) begin
          cur_col = 0;
        end else if (ch == tcc_pkg::CHAR_LF) begin
          emit(tcc_pkg::CMD_HIDE, c, r, 8'd0);
          held = advance_line(lastr);
        end else if (ch == tcc_pkg::CHAR_TAB) begin
          nc = (c / tcc_pkg::TAB_COLUMNS + 1) * tcc_pkg::TAB_COLUMNS;
          if (nc >= lastc) begin
            emit(tcc_pkg::CMD_HIDE, c, r, 8'd0);
            held = advance_line(lastr);
          end else begin
            cur_col = nc;
          end
        end else begin
          emit(tcc_pkg::CMD_DRAW, c, r, ch);
          if (c >= lastc) begin
            emit(tcc_pkg::CMD_HIDE, c, r, 8'd0);
            held = advance_line(lastr);
          end else begin
            cur_col = c + 1;
          end
        end
      end
      tcc_pkg::MODE_BACKSPACE: begin
        emit(tcc_pkg::CMD_CLEAR, c, r, 8'd0);
        if (c == 0) begin
          if (r != 0) begin
            cur_col = lastc;
            cur_row = r - 1;
          end
        end else begin
          cur_col = (c - 1 > lastc) ? lastc : c - 1;
        end
        emit(tcc_pkg::CMD_CLEAR, cur_col, cur_row, 8'd0);
        if (cur_shown) emit(tcc_pkg::CMD_SHOW, cur_col, cur_row, 8'd0);
      end
      tcc_pkg::MODE_UP, tcc_pkg::MODE_DOWN, tcc_pkg::MODE_LEFT, tcc_pkg::MODE_RIGHT: begin
        // arrow at the edge moves nothing and emits nothing
        if (!((mode == tcc_pkg::MODE_UP && r == 0) ||
              (mode == tcc_pkg::MODE_DOWN && r >= lastr) ||
              (mode == tcc_pkg::MODE_LEFT && c == 0) ||
              (mode == tcc_pkg::MODE_RIGHT && c >= lastc))) begin
          emit(tcc_pkg::CMD_HIDE, c, r, 8'd0);
          case (mode)
            tcc_pkg::MODE_UP: cur_row = r - 1;
            tcc_pkg::MODE_DOWN: cur_row = r + 1;
            tcc_pkg::MODE_LEFT: cur_col = (c - 1 > lastc) ? lastc : c - 1;
            default: cur_col = c + 1;
          endcase
          if (cur_shown) emit(tcc_pkg::CMD_SHOW, cur_col, cur_row, 8'd0);
        end
      end
      tcc_pkg::MODE_BLINK: begin
        cur_shown = !cur_shown;
        emit(cur_shown ? tcc_pkg::CMD_SHOW : tcc_pkg::CMD_HIDE, c, r, 8'd0);
      end
      default: ;
    endcase
    cur_col = cur_col & 255;
    cur_row = cur_row & 127;
    foreach (step_cmds[k]) begin
      step_cmds[k].held = held;
      step_cmds[k].last = (k == step_cmds.size() - 1);
      cmds_due.push_back(step_cmds[k]);
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    console_req_t req;
    bit v;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_cursor(s_tuser, s_tdata);
        reqs_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        v = 1'b0;
        if (src_wait > 0) begin
          src_wait--;
        end else if (console_reqs.size() > 0) begin
          req = console_reqs.pop_front();
          s_tuser <= req.mode;
          s_tdata <= req.ch;
          v = 1'b1;
          if (!calm_src) src_wait = pick_gap();
        end
        s_tvalid <= v;
      end
    end
  end

  // command monitor and back-pressure
  always @(posedge clk) begin
    cell_cmd_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (cmds_due.size() == 0) begin
          $display("%0t: expected no command, actual command %0d col %0d row %0d", $time,
                   m_tuser, m_tdata[7:0], m_tdata[14:8]);
          errors++;
        end else begin
          want = cmds_due.pop_front();
          check_field("command", 8'(want.item.command), 8'(m_tuser));
          check_field("cell_column", want.item.col, m_tdata[7:0]);
          check_field("cell_row", 8'(want.item.row), 8'(m_tdata[14:8]));
          check_field("glyph_code", want.item.glyph, m_tdata[22:15]);
          check_field("row_saturated", 8'(want.held), 8'(m_tdata[23]));
          check_field("last", 8'(want.last), 8'(m_tlast));
        end
      end
      if (sink_wait > 0) begin
        sink_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm_sink && $urandom_range(0, 3) == 0) sink_wait = pick_gap();
      end
    end
  end

  task automatic queue_req(logic [tcc_pkg::MODE_W-1:0] mode, logic [tcc_pkg::CHAR_W-1:0] ch);
    console_req_t req;
    req.mode = mode;
    req.ch = ch;
    console_reqs.push_back(req);
    reqs_queued++;
  endtask

  task automatic queue_random_req();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) queue_req(tcc_pkg::MODE_CHAR, 8'($urandom_range(0, 255)));
    else if (pick < 35) queue_req(tcc_pkg::MODE_CHAR, tcc_pkg::CHAR_CR);
    else if (pick < 43) queue_req(tcc_pkg::MODE_CHAR, tcc_pkg::CHAR_LF);
    else if (pick < 53) queue_req(tcc_pkg::MODE_CHAR, tcc_pkg::CHAR_TAB);
    else if (pick < 61) queue_req(tcc_pkg::MODE_BACKSPACE, 8'($urandom_range(0, 255)));
    else if (pick < 86) queue_req(3'(tcc_pkg::MODE_UP + $urandom_range(0, 3)),
                                  8'($urandom_range(0, 255)));
    else if (pick < 96) queue_req(tcc_pkg::MODE_BLINK, 8'($urandom_range(0, 255)));
    else queue_req(MODE_UNUSED, 8'($urandom_range(0, 255)));
  endtask

  // wait until every request is taken and every command seen, then let the pipe empty
  task automatic settle(int extra);
    while (reqs_accepted != reqs_queued || cmds_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [tcc_pkg::CFG_INDEX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[8:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tcc_pkg::REG_SCREEN_COLUMNS) size_cols = value[8:0];
    else size_rows = value[7:0];
  endtask

  initial begin
    int cols, rows, sel;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // default 128 x 48 screen
    queue_req(tcc_pkg::MODE_BLINK, 8'h00);
    queue_req(tcc_pkg::MODE_CHAR, 8'h41);
    queue_req(tcc_pkg::MODE_CHAR, 8'hFF);
    queue_req(tcc_pkg::MODE_CHAR, tcc_pkg::CHAR_TAB);
    queue_req(tcc_pkg::MODE_CHAR, tcc_pkg::CHAR_CR);
    queue_req(tcc_pkg::MODE_CHAR, tcc_pkg::CHAR_LF);
    queue_req(tcc_pkg::MODE_UP, 8'h00);
    queue_req(tcc_pkg::MODE_UP, 8'hFF);
    queue_req(tcc_pkg::MODE_LEFT, 8'h00);
    queue_req(tcc_pkg::MODE_RIGHT, 8'h00);
    queue_req(tcc_pkg::MODE_DOWN, 8'h00);
    queue_req(tcc_pkg::MODE_LEFT, 8'h00);
    queue_req(tcc_pkg::MODE_BACKSPACE, 8'h00);   // wraps to last column of row 0
    queue_req(tcc_pkg::MODE_RIGHT, 8'h00);       // already at last column
    queue_req(tcc_pkg::MODE_CHAR, 8'h00);        // glyph at last column wraps
    queue_req(tcc_pkg::MODE_BACKSPACE, 8'h00);
    queue_req(MODE_UNUSED, 8'h80);
    queue_req(tcc_pkg::MODE_BLINK, 8'h00);
    queue_req(tcc_pkg::MODE_BACKSPACE, 8'h00);
    settle(16);

    // 8 x 2: cursor now beyond the right edge, tab wrap, held line advance
    write_reg(tcc_pkg::REG_SCREEN_COLUMNS, 8);
    write_reg(tcc_pkg::REG_SCREEN_ROWS, 2);
    queue_req(tcc_pkg::MODE_CHAR, 8'h7E);
    queue_req(tcc_pkg::MODE_CHAR, tcc_pkg::CHAR_TAB);
    queue_req(tcc_pkg::MODE_CHAR, tcc_pkg::CHAR_TAB);
    queue_req(tcc_pkg::MODE_CHAR, tcc_pkg::CHAR_LF);
    queue_req(tcc_pkg::MODE_DOWN, 8'h00);
    settle(16);

    // zero sizes act as one cell
    write_reg(tcc_pkg::REG_SCREEN_COLUMNS, 0);
    write_reg(tcc_pkg::REG_SCREEN_ROWS, 0);
    queue_req(tcc_pkg::MODE_CHAR, 8'h20);
    queue_req(tcc_pkg::MODE_BACKSPACE, 8'h00);
    queue_req(tcc_pkg::MODE_RIGHT, 8'h00);
    queue_req(tcc_pkg::MODE_BLINK, 8'h00);
    settle(16);

    // oversize registers clamp to 256 x 128
    write_reg(tcc_pkg::REG_SCREEN_COLUMNS, 511);
    write_reg(tcc_pkg::REG_SCREEN_ROWS, 255);
    queue_req(tcc_pkg::MODE_CHAR, tcc_pkg::CHAR_LF);
    queue_req(tcc_pkg::MODE_RIGHT, 8'h00);
    queue_req(tcc_pkg::MODE_CHAR, 8'h7F);
    settle(16);

    for (int p = 0; p < 8; p++) begin
      sel = $urandom_range(0, 5);
      case (sel)
        0: cols = $urandom_range(0, 1);
        1: cols = $urandom_range(2, 12);
        2: cols = 256;
        3: cols = $urandom_range(0, 511);
        default: cols = $urandom_range(2, 40);
      endcase
      sel = $urandom_range(0, 5);
      case (sel)
        0: rows = $urandom_range(0, 1);
        1: rows = $urandom_range(2, 6);
        2: rows = 128;
        3: rows = $urandom_range(0, 255);
        default: rows = $urandom_range(2, 12);
      endcase
      sel = $urandom_range(0, 3);
      if (sel != 0) write_reg(tcc_pkg::REG_SCREEN_COLUMNS, cols);
      if (sel != 1) write_reg(tcc_pkg::REG_SCREEN_ROWS, rows);
      calm_src = ($urandom_range(0, 3) == 0);
      calm_sink = ($urandom_range(0, 3) == 0);
      repeat (16) queue_random_req();
      settle(16);
    end
    settle(40);

    if (errors == 0) $display("text_console_cursor_controller: match");
    else $display("text_console_cursor_controller: mismatch");
    $finish;
  end

endmodule
